// ===== rtl/query_keyword_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer modules.
// Each expects clk and rst in scope.
`ifndef QUERY_KEYWORD_TOKENIZER_DEFINES_SVH
`define QUERY_KEYWORD_TOKENIZER_DEFINES_SVH

// Same-cycle implication.
`define QKT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication.
`define QKT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

// ===== rtl/qkt_pkg.sv =====
package qkt_pkg;

  localparam int NumKw = 11;

  // Token type codes
  localparam logic [4:0] TokLbrack  = 5'd0;
  localparam logic [4:0] TokRbrack  = 5'd1;
  localparam logic [4:0] TokLbrace  = 5'd2;
  localparam logic [4:0] TokRbrace  = 5'd3;
  localparam logic [4:0] TokColon   = 5'd4;
  localparam logic [4:0] TokComma   = 5'd5;
  localparam logic [4:0] TokString  = 5'd6;
  localparam logic [4:0] TokNumber  = 5'd7;
  localparam logic [4:0] TokUnknown = 5'd8;
  localparam logic [4:0] TokKw0     = 5'd9;
  localparam logic [4:0] TokEnd     = 5'd20;

  // Result kinds
  localparam logic KindValue = 1'b0;
  localparam logic KindClose = 1'b1;

  // Input modes
  localparam logic ModeByte = 1'b0;
  localparam logic ModeEnd  = 1'b1;

  typedef enum logic [1:0] {
    SCAN_IDLE  = 2'd0,
    SCAN_STR   = 2'd1,
    SCAN_NUM   = 2'd2,
    SCAN_IDENT = 2'd3
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t          mode;
    logic [2:0]          ident_len;
    logic [NumKw-1:0]    kw_match;
  } lex_state_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] ttype;
    logic [7:0] vbyte;
  } result_t;

  // Keyword text, left aligned, zero padded to six characters
  function automatic logic [47:0] kw_word(input logic [3:0] k);
    logic [47:0] w;
    w = '0;
    unique case (k)
      4'd0:  w = "INSERT";
      4'd1:  w = {"GET", 24'h0};
      4'd2:  w = "DELETE";
      4'd3:  w = "CREATE";
      4'd4:  w = "UPDATE";
      4'd5:  w = {"INDEX", 8'h0};
      4'd6:  w = {"ON", 32'h0};
      4'd7:  w = {"SET", 24'h0};
      4'd8:  w = {"WHERE", 8'h0};
      4'd9:  w = {"INTO", 16'h0};
      4'd10: w = {"FROM", 16'h0};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] n;
    n = '0;
    unique case (k)
      4'd0, 4'd2, 4'd3, 4'd4: n = 3'd6;
      4'd1, 4'd7:             n = 3'd3;
      4'd5, 4'd8:             n = 3'd5;
      4'd6:                   n = 3'd2;
      4'd9, 4'd10:            n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  // Character of keyword k at position pos
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
    logic [47:0] sh;
    sh = kw_word(k) << {pos, 3'b000};
    return sh[47:40];
  endfunction

endpackage

// ===== rtl/qkt_in_if.sv =====
interface qkt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// ===== rtl/qkt_out_if.sv =====
interface qkt_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [4:0] token_type;
  logic [7:0] value_byte;
  logic       last_of_run;

  modport source (output valid, output result_kind, output token_type,
                  output value_byte, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input token_type,
                  input value_byte, input last_of_run, output ready);
endinterface

// ===== rtl/query_keyword_tokenizer.sv =====
// Byte-serial query tokenizer. Each input beat carries one text byte or an
// end-of-input mark and yields zero to three result beats: value bytes of the
// current token followed by a close beat with its type, last_of_run marking
// the final beat of each input. The byte passes an input register, is lexed
// combinationally against the scan state, and its results are loaded into a
// three-entry result queue that drains one beat per cycle while the output is
// ready. The queue's single output port sets the rate: it takes another input
// only once empty or as its last beat drains, so plain token text runs at one
// byte per cycle while the output is ready, and a terminator that closes a
// token and opens a punctuation token holds input until its last result drains.
`include "query_keyword_tokenizer_defines.svh"

module query_keyword_tokenizer (
  input logic       clk,
  input logic       rst,
  qkt_in_if.sink    item,
  qkt_out_if.source result
);

  logic                s1_valid;
  logic                s1_mode;
  logic [7:0]          s1_byte;
  logic                load;
  logic                can_load;
  qkt_pkg::lex_state_t state;
  qkt_pkg::lex_state_t state_next;
  qkt_pkg::result_t    results [3];
  logic [1:0]          count;

  assign load = s1_valid && can_load;
  assign item.ready = !s1_valid || load;

  // Hold the accepted beat until the result queue can take its run
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_mode <= item.mode;
      s1_byte <= item.data_byte;
    end
  end

  // Scan state advances as each run is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= qkt_pkg::SCAN_IDLE;
      state.ident_len <= '0;
      state.kw_match <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

  qkt_lexer u_lexer (
    .state      (state),
    .mode       (s1_mode),
    .data_byte  (s1_byte),
    .state_next (state_next),
    .results    (results),
    .count      (count)
  );

  qkt_result_buf u_result_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .results  (results),
    .count    (count),
    .can_load (can_load),
    .dst      (result)
  );

  `QKT_ASSERT_NXT(a_end_returns_idle, load && (s1_mode == qkt_pkg::ModeEnd),
                  state.mode == qkt_pkg::SCAN_IDLE)
  `QKT_ASSERT_IMP(a_ident_has_length, state.mode == qkt_pkg::SCAN_IDENT,
                  state.ident_len != 3'd0)
  `QKT_ASSERT_NXT(a_end_emits_result, load && (s1_mode == qkt_pkg::ModeEnd),
                  result.valid)

endmodule

// ===== rtl/qkt_lexer.sv =====
module qkt_lexer (
  input  qkt_pkg::lex_state_t state,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  output qkt_pkg::lex_state_t state_next,
  output qkt_pkg::result_t    results [3],
  output logic [1:0]          count
);

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic qkt_pkg::result_t mk(input logic kind, input logic [4:0] tt,
                                          input logic [7:0] vb);
    qkt_pkg::result_t r;
    r.kind  = kind;
    r.ttype = tt;
    r.vbyte = vb;
    return r;
  endfunction

  logic [7:0]                 c;
  logic                       ident_ch;
  logic [qkt_pkg::NumKw-1:0]  match_adv;
  logic [2:0]                 len_adv;
  logic [qkt_pkg::NumKw-1:0]  match_fresh;
  logic [4:0]                 ident_type;
  qkt_pkg::result_t           ia0, ia1;
  logic [1:0]                 ic;
  qkt_pkg::lex_state_t        idle_next;
  logic                       pre;
  qkt_pkg::result_t           pre_r;
  qkt_pkg::result_t           t0, t1;
  logic [1:0]                 tn;

  assign c = data_byte;
  assign ident_ch = is_alpha(c) || is_digit(c) || (c == "_");

  // Advance the keyword prefix match by one character
  always_comb begin
    for (int k = 0; k < qkt_pkg::NumKw; k++) begin
      match_adv[k] = state.kw_match[k] && (state.ident_len < qkt_pkg::kw_len(4'(k)))
                     && (qkt_pkg::kw_char(4'(k), state.ident_len) == c);
      match_fresh[k] = (qkt_pkg::kw_char(4'(k), 3'd0) == c);
    end
    len_adv = (state.ident_len == 3'd7) ? 3'd7 : state.ident_len + 3'd1;
  end

  // Pick the first keyword that matches in full
  always_comb begin
    ident_type = qkt_pkg::TokString;
    for (int k = qkt_pkg::NumKw - 1; k >= 0; k--) begin
      if (state.kw_match[k] && (state.ident_len == qkt_pkg::kw_len(4'(k))))
        ident_type = qkt_pkg::TokKw0 + 5'(k);
    end
  end

  // Lex a byte from idle
  always_comb begin
    ia0 = '0;
    ia1 = '0;
    ic = 2'd0;
    idle_next = state;
    idle_next.mode = qkt_pkg::SCAN_IDLE;
    if (is_space(c)) begin
      ic = 2'd0;
    end else if (c == "[" || c == "]" || c == "{" || c == "}" || c == ":" || c == ",") begin
      ia0 = mk(qkt_pkg::KindValue, 5'd0, c);
      ic = 2'd2;
      case (c)
        "[":     ia1 = mk(qkt_pkg::KindClose, qkt_pkg::TokLbrack, 8'd0);
        "]":     ia1 = mk(qkt_pkg::KindClose, qkt_pkg::TokRbrack, 8'd0);
        "{":     ia1 = mk(qkt_pkg::KindClose, qkt_pkg::TokLbrace, 8'd0);
        "}":     ia1 = mk(qkt_pkg::KindClose, qkt_pkg::TokRbrace, 8'd0);
        ":":     ia1 = mk(qkt_pkg::KindClose, qkt_pkg::TokColon, 8'd0);
        default: ia1 = mk(qkt_pkg::KindClose, qkt_pkg::TokComma, 8'd0);
      endcase
    end else if (c == "\"") begin
      idle_next.mode = qkt_pkg::SCAN_STR;
    end else if (is_digit(c)) begin
      ia0 = mk(qkt_pkg::KindValue, 5'd0, c);
      ic = 2'd1;
      idle_next.mode = qkt_pkg::SCAN_NUM;
    end else if (is_alpha(c) || c == "_") begin
      ia0 = mk(qkt_pkg::KindValue, 5'd0, c);
      ic = 2'd1;
      idle_next.mode = qkt_pkg::SCAN_IDENT;
      idle_next.ident_len = 3'd1;
      idle_next.kw_match = match_fresh;
    end else begin
      ia0 = mk(qkt_pkg::KindValue, 5'd0, c);
      ia1 = mk(qkt_pkg::KindClose, qkt_pkg::TokUnknown, 8'd0);
      ic = 2'd2;
    end
  end

  // Select results and next state for the current mode
  always_comb begin
    state_next = state;
    pre = 1'b0;
    pre_r = '0;
    t0 = ia0;
    t1 = ia1;
    tn = ic;
    if (mode == qkt_pkg::ModeEnd) begin
      pre = (state.mode != qkt_pkg::SCAN_IDLE);
      case (state.mode)
        qkt_pkg::SCAN_STR:   pre_r = mk(qkt_pkg::KindClose, qkt_pkg::TokUnknown, 8'd0);
        qkt_pkg::SCAN_NUM:   pre_r = mk(qkt_pkg::KindClose, qkt_pkg::TokNumber, 8'd0);
        default:             pre_r = mk(qkt_pkg::KindClose, ident_type, 8'd0);
      endcase
      t0 = mk(qkt_pkg::KindClose, qkt_pkg::TokEnd, 8'd0);
      t1 = '0;
      tn = 2'd1;
      state_next.mode = qkt_pkg::SCAN_IDLE;
      state_next.ident_len = '0;
      state_next.kw_match = '0;
    end else begin
      unique case (state.mode)
        qkt_pkg::SCAN_STR: begin
          t1 = '0;
          tn = 2'd1;
          if (c == "\"") begin
            t0 = mk(qkt_pkg::KindClose, qkt_pkg::TokString, 8'd0);
            state_next.mode = qkt_pkg::SCAN_IDLE;
          end else begin
            t0 = mk(qkt_pkg::KindValue, 5'd0, c);
          end
        end
        qkt_pkg::SCAN_NUM: begin
          if (is_digit(c)) begin
            t0 = mk(qkt_pkg::KindValue, 5'd0, c);
            t1 = '0;
            tn = 2'd1;
          end else begin
            pre = 1'b1;
            pre_r = mk(qkt_pkg::KindClose, qkt_pkg::TokNumber, 8'd0);
            state_next = idle_next;
          end
        end
        qkt_pkg::SCAN_IDENT: begin
          if (ident_ch) begin
            t0 = mk(qkt_pkg::KindValue, 5'd0, c);
            t1 = '0;
            tn = 2'd1;
            state_next.ident_len = len_adv;
            state_next.kw_match = match_adv;
          end else begin
            pre = 1'b1;
            pre_r = mk(qkt_pkg::KindClose, ident_type, 8'd0);
            state_next = idle_next;
          end
        end
        default: begin
          state_next = idle_next;
        end
      endcase
    end
  end

  // Pack the close of the open token ahead of the rest
  always_comb begin
    if (pre) begin
      results[0] = pre_r;
      results[1] = t0;
      results[2] = t1;
      count = tn + 2'd1;
    end else begin
      results[0] = t0;
      results[1] = t1;
      results[2] = '0;
      count = tn;
    end
  end

endmodule

// ===== rtl/qkt_result_buf.sv =====
`include "query_keyword_tokenizer_defines.svh"

module qkt_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  qkt_pkg::result_t results [3],
  input  logic [1:0]       count,
  output logic             can_load,
  qkt_out_if.source        dst
);

  qkt_pkg::result_t slots [3];
  logic [1:0]       cnt;
  logic             drain;

  assign drain = (cnt != 2'd0) && dst.ready;
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && dst.ready);

  // Count of beats still waiting
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= count;
    end else if (drain) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Load a new run, or advance the queue by one beat
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= results;
    end else if (drain) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

  assign dst.valid       = (cnt != 2'd0);
  assign dst.result_kind = slots[0].kind;
  assign dst.token_type  = slots[0].ttype;
  assign dst.value_byte  = slots[0].vbyte;
  assign dst.last_of_run = (cnt == 2'd1);

  `QKT_ASSERT_IMP(a_load_only_when_free, load, (cnt == 2'd0) || (cnt == 2'd1 && drain))
  `QKT_ASSERT_NXT(a_drain_counts_down, drain && !load, cnt == $past(cnt) - 2'd1)
  `QKT_ASSERT_IMP(a_value_beat_type_zero,
                  dst.valid && (dst.result_kind == qkt_pkg::KindValue),
                  dst.token_type == 5'd0)

endmodule
